// ===== hdl/glg_pkg.sv =====
package glg_pkg;

    localparam int GLG_MAX_HEIGHT = 256;
    localparam int GLG_MAX_WIDTH  = 256;

    localparam logic [8:0]  ROW_COUNT_RST = 9'd64;
    localparam logic [8:0]  COL_COUNT_RST = 9'd64;
    localparam logic [23:0] NEG_COEF_RST  = 24'd20972;

    // log2(e) in Q24, ln(2) in Q30, 1.0 in Q30
    localparam logic [24:0] LOG2E_Q24 = 25'd24204406;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

    // exponent argument 12.0 in Q16 and above gives a zero label
    localparam logic [39:0] SAT_LIMIT = 40'd786432;

    typedef struct packed {
        logic [8:0]  row_cnt;
        logic [8:0]  col_cnt;
        logic [23:0] neg_coef;
    } t_cfg;

    function automatic logic [63:0] f_isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bt;
        logic [63:0] rem;
        res = '0;
        bt  = 64'd1 << 62;
        rem = v;
        for (int k = 0; k < 32; k++) begin
            if (bt != '0) begin
                if (rem >= res + bt) begin
                    rem = rem - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
        end
        return res;
    endfunction

    // 2^(-1/2^idx) in Q30, by repeated integer square roots of 0.5
    function automatic logic [29:0] f_root(input int idx);
        logic [63:0] root;
        root = 64'd1 << 29;
        for (int k = 1; k <= 8; k++) begin
            if (k <= idx) begin
                root = f_isqrt(root << 30);
            end
        end
        return root[29:0];
    endfunction

    localparam logic [29:0] ROOT_TAB [1:8] = '{
        f_root(1), f_root(2), f_root(3), f_root(4),
        f_root(5), f_root(6), f_root(7), f_root(8)
    };

endpackage

// ===== hdl/glg_cfg.sv =====
module glg_cfg
    import glg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    localparam logic [1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [1:0] REG_COL_COUNT = 2'd1;
    localparam logic [1:0] REG_NEG_COEF  = 2'd2;

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row_cnt  <= ROW_COUNT_RST;
            r_cfg.col_cnt  <= COL_COUNT_RST;
            r_cfg.neg_coef <= NEG_COEF_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_ROW_COUNT: r_cfg.row_cnt  <= pwdata[8:0];
                REG_COL_COUNT: r_cfg.col_cnt  <= pwdata[8:0];
                REG_NEG_COEF:  r_cfg.neg_coef <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_ROW_COUNT: prdata = {23'd0, r_cfg.row_cnt};
            REG_COL_COUNT: prdata = {23'd0, r_cfg.col_cnt};
            REG_NEG_COEF:  prdata = {8'd0, r_cfg.neg_coef};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/glg_offset.sv =====
module glg_offset
    import glg_pkg::*;
#(
    parameter int MAX_HEIGHT = GLG_MAX_HEIGHT,
    parameter int MAX_WIDTH  = GLG_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_col,
    input  t_cfg        i_cfg,
    input  logic        i_take_next,
    output logic        o_take,
    output logic        o_vld,
    output logic [16:0] o_d2,
    output logic        o_bad
);

    logic [8:0]  h;
    logic [8:0]  w;
    logic [8:0]  half_h;
    logic [8:0]  half_w;
    logic [8:0]  ad_r;
    logic [8:0]  ad_c;
    logic [15:0] sq_r;
    logic [15:0] sq_c;
    logic [16:0] d2_sum;
    logic        n_bad;

    logic        r_vld;
    logic [16:0] r_d2;
    logic        r_bad;

    always_comb begin
        h = (int'(i_cfg.row_cnt) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : i_cfg.row_cnt;
        w = (int'(i_cfg.col_cnt) > MAX_WIDTH)  ? 9'(MAX_WIDTH)  : i_cfg.col_cnt;
        n_bad  = ({1'b0, i_row} >= h) || ({1'b0, i_col} >= w);
        half_h = h - (h >> 1);
        half_w = w - (w >> 1);
        // distance from the circularly shifted peak
        ad_r = ({1'b0, i_row} <= half_h) ? {1'b0, i_row} : h - {1'b0, i_row};
        ad_c = ({1'b0, i_col} <= half_w) ? {1'b0, i_col} : w - {1'b0, i_col};
        sq_r = ad_r[7:0] * ad_r[7:0];
        sq_c = ad_c[7:0] * ad_c[7:0];
        d2_sum = {1'b0, sq_r} + {1'b0, sq_c};
    end

    assign o_take = !r_vld || i_take_next;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_take) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_d2  <= d2_sum;
            r_bad <= n_bad;
        end
    end

    assign o_vld = r_vld;
    assign o_d2  = r_d2;
    assign o_bad = r_bad;

    a_d2_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !r_bad |-> r_d2 <= 17'd130050)
        else $error("squared distance out of range");

endmodule

// ===== hdl/glg_exp.sv =====
module glg_exp
    import glg_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    input  logic [16:0] i_d2,
    input  logic        i_bad,
    input  t_cfg        i_cfg,
    input  logic        i_stall,
    output logic        o_take,
    output logic        o_vld,
    output logic [15:0] o_label,
    output logic        o_bad
);

    // stages: 0 coef mult, 1 log2e mult, 2 linear term, 3..10 table, 11 final mult,
    // 12 rounding shift / output
    localparam int NS = 13;
    localparam int LB = 3;

    typedef struct packed {
        logic       bad;
        logic       sat;
        logic [4:0] n;
    } t_ctl;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] take;

    logic        r0_bad;
    logic        r0_sat;
    logic [19:0] r0_x;

    logic        r1_bad;
    logic        r1_sat;
    logic [4:0]  r1_n;
    logic [39:0] r1_f;

    t_ctl        r2_ctl;
    logic [7:0]  r2_fhi;
    logic [21:0] r2_lin;

    t_ctl        r_lctl [8];
    logic [7:0]  r_lfhi [8];
    logic [30:0] r_lq   [8];
    logic [30:0] r_lm   [8];

    t_ctl        r_fctl;
    logic [30:0] r_fm;

    logic [15:0] r_label;
    logic        r_bad;

    logic [40:0] x_full;
    logic [44:0] y_full;
    logic [61:0] lin_prod;
    logic [61:0] fin_prod;
    logic [5:0]  sh;
    logic [32:0] rnd_sum;
    logic [32:0] rnd_shr;

    always_comb begin
        take[NS-1] = !r_vld[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            take[k] = !r_vld[k] || take[k+1];
        end
    end

    assign o_take = take[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (take[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int k = 1; k < NS; k++) begin
                if (take[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // stage 0: x = coef * d2 in Q16
    assign x_full = i_cfg.neg_coef * i_d2;

    always_ff @(posedge i_clk) begin
        if (take[0]) begin
            r0_bad <= i_bad;
            r0_sat <= x_full >= SAT_LIMIT;
            r0_x   <= x_full[19:0];
        end
    end

    // stage 1: y = x * log2(e), integer part n and 40-bit fraction
    assign y_full = r0_x * LOG2E_Q24;

    always_ff @(posedge i_clk) begin
        if (take[1]) begin
            r1_bad <= r0_bad;
            r1_sat <= r0_sat;
            r1_n   <= y_full[44:40];
            r1_f   <= y_full[39:0];
        end
    end

    // stage 2: first-order term for the low 32 fraction bits
    assign lin_prod = r1_f[31:0] * LN2_Q30;

    always_ff @(posedge i_clk) begin
        if (take[2]) begin
            r2_ctl <= '{bad: r1_bad, sat: r1_sat, n: r1_n};
            r2_fhi <= r1_f[39:32];
            r2_lin <= lin_prod[61:40];
        end
    end

    // stages 3..10: one table factor per top fraction bit
    for (genvar k = 0; k < 8; k++) begin : g_tab
        logic [30:0] m_in;
        logic [30:0] q_in;
        t_ctl        ctl_in;
        logic [7:0]  fhi_in;
        logic [60:0] prod;

        if (k == 0) begin : g_first
            assign m_in   = ONE_Q30;
            assign q_in   = ONE_Q30 - {9'd0, r2_lin};
            assign ctl_in = r2_ctl;
            assign fhi_in = r2_fhi;
        end else begin : g_next
            assign m_in   = r_lm[k-1];
            assign q_in   = r_lq[k-1];
            assign ctl_in = r_lctl[k-1];
            assign fhi_in = r_lfhi[k-1];
        end

        assign prod = m_in * ROOT_TAB[k+1];

        always_ff @(posedge i_clk) begin
            if (take[LB+k]) begin
                r_lctl[k] <= ctl_in;
                r_lfhi[k] <= fhi_in;
                r_lq[k]   <= q_in;
                r_lm[k]   <= fhi_in[7-k] ? prod[60:30] : m_in;
            end
        end
    end

    // stage 11: apply linear term
    assign fin_prod = r_lm[7] * r_lq[7];

    always_ff @(posedge i_clk) begin
        if (take[NS-2]) begin
            r_fctl <= r_lctl[7];
            r_fm   <= fin_prod[60:30];
        end
    end

    // stage 12: scale by 2^-n with rounding into Q1.15
    always_comb begin
        sh      = 6'(r_fctl.n) + 6'd14;
        rnd_sum = {2'b00, r_fm} + (33'd1 << sh);
        rnd_shr = rnd_sum >> (sh + 6'd1);
    end

    always_ff @(posedge i_clk) begin
        if (take[NS-1]) begin
            r_bad   <= r_fctl.bad;
            r_label <= (r_fctl.bad || r_fctl.sat) ? 16'd0 : rnd_shr[15:0];
        end
    end

    assign o_vld   = r_vld[NS-1];
    assign o_label = r_label;
    assign o_bad   = r_bad;

    a_label_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] |-> r_label <= 16'd32768)
        else $error("label above 1.0");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] && r_bad |-> r_label == 16'd0)
        else $error("bad index with nonzero label");

    a_tab_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LB+7] && !take[LB+7] |=> $stable(r_lm[7]) && r_vld[LB+7])
        else $error("stalled table stage lost its word");

endmodule

// ===== hdl/gaussian_label_generator_top.sv =====
// Gaussian label generator: returns the correlation-filter target
// exp(-coef*(dr^2+dc^2)) in unsigned Q1.15 for one (row, col) pixel per word.
// Input channel: i_valid/o_stall with i_row, i_col. Output channel:
// o_valid/i_stall with o_label, o_bad_index (set, with label 0, when the index
// lies outside the configured map size).
// Registers over the APB port: 0x0 row_count, 0x4 col_count, 0x8 neg_coef.
// Write them only while no word is in flight.
// A word passes from input acceptance to o_valid through one stage for the
// circular offsets, then the exponential pipeline (coefficient multiply,
// log2(e) multiply, linear term, eight table-factor multiplies, final multiply,
// rounding shift). Throughput is one word per cycle while i_stall is low.
// Each stage holds its word with a valid bit; a stalled output only holds the
// stages behind it that are full, so bubbles still fill and input is taken
// until the whole pipe is occupied.
// Reset clears all valid bits and loads the register defaults (64, 64, 20972).
module gaussian_label_generator_top
    import glg_pkg::*;
#(
    parameter int MAX_HEIGHT = GLG_MAX_HEIGHT,
    parameter int MAX_WIDTH  = GLG_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_row,
    input  logic [7:0]  i_col,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_label,
    output logic        o_bad_index,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg        cfg;
    logic        off_take;
    logic        off_vld;
    logic [16:0] off_d2;
    logic        off_bad;
    logic        exp_take;

    glg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    glg_offset #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_offset (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (i_valid),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_cfg       (cfg),
        .i_take_next (exp_take),
        .o_take      (off_take),
        .o_vld       (off_vld),
        .o_d2        (off_d2),
        .o_bad       (off_bad)
    );

    glg_exp u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (off_vld),
        .i_d2    (off_d2),
        .i_bad   (off_bad),
        .i_cfg   (cfg),
        .i_stall (i_stall),
        .o_take  (exp_take),
        .o_vld   (o_valid),
        .o_label (o_label),
        .o_bad   (o_bad_index)
    );

    assign o_stall = !off_take;

endmodule
